// ===== hdl/tbs_pkg.sv =====
// Shared types and constants for the two-axis bounce scan unit.
// Holds the configuration record, register codes and angle limits.
// No dependencies; the register file, the core, the top level and the testbench import this package.
`timescale 1ns / 1ps

package tbs_pkg;

    // APB address width: seven word registers at byte addresses 0 to 24.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register codes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_SCAN_SPEED   = 3'd0,
        REG_PITCH_CONT   = 3'd1,
        REG_CR_PITCH_MAX = 3'd2,
        REG_CR_PITCH_MIN = 3'd3,
        REG_PITCH_RANGE  = 3'd4,
        REG_YAW_TRIM     = 3'd5,
        REG_PITCH_TRIM   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic        [6:0]  scan_speed_dps;
        logic               pitch_continuous_servo;
        logic signed [14:0] cr_pitch_max_cdeg;
        logic signed [14:0] cr_pitch_min_cdeg;
        logic        [7:0]  pitch_range_deg;
        logic signed [10:0] yaw_trim_cdeg;
        logic signed [10:0] pitch_trim_cdeg;
    } cfg_t;

    // Reset values of the configuration registers.
    localparam logic        [6:0]  SCAN_SPEED_RST   = 7'd2;
    localparam logic signed [14:0] CR_PITCH_MAX_RST = 15'sd9000;
    localparam logic signed [14:0] CR_PITCH_MIN_RST = -15'sd9000;
    localparam logic        [7:0]  PITCH_RANGE_RST  = 8'd180;

    // Angle limits in centidegrees.
    localparam logic signed [17:0] BEARING_FULL    = 18'sd36000;
    localparam logic signed [17:0] BEARING_HALF    = 18'sd18000;
    localparam logic signed [15:0] PITCH_OUT_LIMIT = 16'sd10000;
    localparam logic        [13:0] CDEG_PER_DEG    = 14'd100;

endpackage

// ===== hdl/tbs_tick_if.sv =====
// Input channel of the bounce scan unit: one tick per transfer.
// Carries valid, ready and the tick flags; no dependencies.
`timescale 1ns / 1ps

interface tbs_tick_if;
    logic valid;
    logic ready;
    logic link_lost;
    logic manual_yaw;
    logic manual_pitch;

    modport source (output valid, output link_lost, output manual_yaw,
                    output manual_pitch, input ready);
    modport sink   (input valid, input link_lost, input manual_yaw,
                    input manual_pitch, output ready);
endinterface

// ===== hdl/tbs_result_if.sv =====
// Output channel of the bounce scan unit: one angle command per transfer.
// Carries valid, ready and the result fields; no dependencies.
`timescale 1ns / 1ps

interface tbs_result_if;
    logic               valid;
    logic               ready;
    logic               switch_to_auto;
    logic signed [15:0] yaw_cmd_cdeg;
    logic signed [14:0] pitch_cmd_cdeg;

    modport source (output valid, output switch_to_auto, output yaw_cmd_cdeg,
                    output pitch_cmd_cdeg, input ready);
    modport sink   (input valid, input switch_to_auto, input yaw_cmd_cdeg,
                    input pitch_cmd_cdeg, output ready);
endinterface

// ===== hdl/tbs_cfg.sv =====
// APB register file of the bounce scan unit.
// Depends on tbs_pkg for the register codes and the configuration record.
`timescale 1ns / 1ps

module tbs_cfg
    import tbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    cfg_index_t idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = cfg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SCAN_SPEED:   cfg_next.scan_speed_dps         = pwdata[6:0];
                REG_PITCH_CONT:   cfg_next.pitch_continuous_servo = pwdata[0];
                REG_CR_PITCH_MAX: cfg_next.cr_pitch_max_cdeg      = pwdata[14:0];
                REG_CR_PITCH_MIN: cfg_next.cr_pitch_min_cdeg      = pwdata[14:0];
                REG_PITCH_RANGE:  cfg_next.pitch_range_deg        = pwdata[7:0];
                REG_YAW_TRIM:     cfg_next.yaw_trim_cdeg          = pwdata[10:0];
                REG_PITCH_TRIM:   cfg_next.pitch_trim_cdeg        = pwdata[10:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_speed_dps         <= SCAN_SPEED_RST;
            cfg_reg.pitch_continuous_servo <= 1'b0;
            cfg_reg.cr_pitch_max_cdeg      <= CR_PITCH_MAX_RST;
            cfg_reg.cr_pitch_min_cdeg      <= CR_PITCH_MIN_RST;
            cfg_reg.pitch_range_deg        <= PITCH_RANGE_RST;
            cfg_reg.yaw_trim_cdeg          <= '0;
            cfg_reg.pitch_trim_cdeg        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Signed registers read back sign-extended.
    always_comb
    begin
        unique case (idx)
            REG_SCAN_SPEED:   prdata = {25'd0, cfg_reg.scan_speed_dps};
            REG_PITCH_CONT:   prdata = {31'd0, cfg_reg.pitch_continuous_servo};
            REG_CR_PITCH_MAX: prdata = {{17{cfg_reg.cr_pitch_max_cdeg[14]}},
                                        cfg_reg.cr_pitch_max_cdeg};
            REG_CR_PITCH_MIN: prdata = {{17{cfg_reg.cr_pitch_min_cdeg[14]}},
                                        cfg_reg.cr_pitch_min_cdeg};
            REG_PITCH_RANGE:  prdata = {24'd0, cfg_reg.pitch_range_deg};
            REG_YAW_TRIM:     prdata = {{21{cfg_reg.yaw_trim_cdeg[10]}},
                                        cfg_reg.yaw_trim_cdeg};
            REG_PITCH_TRIM:   prdata = {{21{cfg_reg.pitch_trim_cdeg[10]}},
                                        cfg_reg.pitch_trim_cdeg};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/tbs_core.sv =====
// Sweep datapath: tick register, bearing and pitch state, result register.
// Depends on tbs_pkg and on the tbs_tick_if and tbs_result_if interfaces.
`timescale 1ns / 1ps

module tbs_core
    import tbs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    tbs_tick_if.sink       tick,
    tbs_result_if.source   result
);

    // Tick register.
    logic               tk_valid_reg;
    logic               tk_link_lost_reg;
    logic               tk_manual_yaw_reg;
    logic               tk_manual_pitch_reg;

    // Sweep state.
    logic        [16:0] bearing_reg;
    logic        [16:0] bearing_next;
    logic               bearing_rev_reg;
    logic               bearing_rev_next;
    logic signed [14:0] pitch_reg;
    logic signed [14:0] pitch_next;
    logic               pitch_rev_reg;
    logic               pitch_rev_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_switch_reg;
    logic signed [15:0] out_yaw_reg;
    logic signed [14:0] out_pitch_reg;
    logic signed [15:0] yaw_out;
    logic signed [14:0] pitch_out;

    logic               out_free;
    logic               tk_fire;

    logic        [7:0]  bear_step;
    logic        [8:0]  pitch_step;
    logic signed [17:0] bear_base;
    logic signed [17:0] bear_step_s;
    logic signed [17:0] bear_sum;
    logic        [13:0] half_x100;
    logic signed [14:0] pmax;
    logic signed [14:0] pmin;
    logic signed [16:0] pmax_x;
    logic signed [16:0] pmin_x;
    logic signed [16:0] pitch_base;
    logic signed [16:0] pitch_step_s;
    logic signed [16:0] pitch_sum;
    logic signed [17:0] yaw_sum;
    logic signed [17:0] yaw_wrap;
    logic signed [17:0] yaw_fold;
    logic signed [15:0] pitch_trimmed;

    assign out_free   = !out_valid_reg || result.ready;
    assign tk_fire    = tk_valid_reg && out_free;
    assign tick.ready = !tk_valid_reg || out_free;

    assign result.valid          = out_valid_reg;
    assign result.switch_to_auto = out_switch_reg;
    assign result.yaw_cmd_cdeg   = out_yaw_reg;
    assign result.pitch_cmd_cdeg = out_pitch_reg;

    always_comb
    begin
        bear_step  = {cfg.scan_speed_dps, 1'b0};
        pitch_step = {2'b00, cfg.scan_speed_dps} + {1'b0, cfg.scan_speed_dps, 1'b0};

        if (cfg.pitch_continuous_servo)
        begin
            half_x100 = '0;
            pmax      = cfg.cr_pitch_max_cdeg;
            pmin      = cfg.cr_pitch_min_cdeg;
        end
        else
        begin
            half_x100 = 14'({7'd0, cfg.pitch_range_deg[7:1]} * CDEG_PER_DEG);
            pmax      = $signed({1'b0, half_x100});
            pmin      = 15'sd0 - $signed({1'b0, half_x100});
        end
        pmax_x = {{2{pmax[14]}}, pmax};
        pmin_x = {{2{pmin[14]}}, pmin};

        bearing_next     = bearing_reg;
        bearing_rev_next = bearing_rev_reg;
        pitch_next       = pitch_reg;
        pitch_rev_next   = pitch_rev_reg;

        // Bearing ramp: step, turn at a passed bound, then clamp.
        bear_base   = $signed({1'b0, bearing_reg});
        bear_step_s = $signed({10'd0, bear_step});
        bear_sum    = bearing_rev_reg ? bear_base - bear_step_s : bear_base + bear_step_s;
        if (tk_link_lost_reg && !tk_manual_yaw_reg)
        begin
            if (bear_sum < 18'sd0 && bearing_rev_reg)
                bearing_rev_next = 1'b0;
            else if (bear_sum > BEARING_FULL && !bearing_rev_reg)
                bearing_rev_next = 1'b1;
            if (bear_sum < 18'sd0)
                bearing_next = '0;
            else if (bear_sum > BEARING_FULL)
                bearing_next = BEARING_FULL[16:0];
            else
                bearing_next = bear_sum[16:0];
        end

        // Pitch ramp; the lower bound wins when the limits cross. With crossed
        // limits a turn forward at the lower bound can be followed at once by a
        // turn back at the upper bound, so the second test sees the first.
        pitch_base   = {{2{pitch_reg[14]}}, pitch_reg};
        pitch_step_s = $signed({8'd0, pitch_step});
        pitch_sum    = pitch_rev_reg ? pitch_base - pitch_step_s
                                     : pitch_base + pitch_step_s;
        if (tk_link_lost_reg && !tk_manual_pitch_reg)
        begin
            if (pitch_sum < pmin_x && pitch_rev_reg)
                pitch_rev_next = 1'b0;
            if (pitch_sum > pmax_x && !pitch_rev_next)
                pitch_rev_next = 1'b1;
            if (pitch_sum < pmin_x)
                pitch_next = pmin;
            else if (pitch_sum > pmax_x)
                pitch_next = pmax;
            else
                pitch_next = pitch_sum[14:0];
        end

        // Trimmed bearing folded into the half-open range above -180 degrees.
        yaw_sum = $signed({1'b0, bearing_next})
                + $signed({{7{cfg.yaw_trim_cdeg[10]}}, cfg.yaw_trim_cdeg});
        if (yaw_sum < 18'sd0)
            yaw_wrap = yaw_sum + BEARING_FULL;
        else if (yaw_sum >= BEARING_FULL)
            yaw_wrap = yaw_sum - BEARING_FULL;
        else
            yaw_wrap = yaw_sum;
        yaw_fold = (yaw_wrap > BEARING_HALF) ? yaw_wrap - BEARING_FULL : yaw_wrap;

        pitch_trimmed = $signed({pitch_next[14], pitch_next})
                      + $signed({{5{cfg.pitch_trim_cdeg[10]}}, cfg.pitch_trim_cdeg});
        if (pitch_trimmed > PITCH_OUT_LIMIT)
            pitch_out = PITCH_OUT_LIMIT[14:0];
        else if (pitch_trimmed < -PITCH_OUT_LIMIT)
            pitch_out = 15'sd0 - PITCH_OUT_LIMIT[14:0];
        else
            pitch_out = pitch_trimmed[14:0];

        if (tk_link_lost_reg)
            yaw_out = yaw_fold[15:0];
        else
        begin
            yaw_out   = '0;
            pitch_out = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tk_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            bearing_reg     <= '0;
            bearing_rev_reg <= 1'b0;
            pitch_reg       <= '0;
            pitch_rev_reg   <= 1'b0;
        end
        else
        begin
            if (tick.valid && tick.ready)
                tk_valid_reg <= 1'b1;
            else if (tk_fire)
                tk_valid_reg <= 1'b0;

            if (tk_fire)
            begin
                out_valid_reg   <= 1'b1;
                bearing_reg     <= bearing_next;
                bearing_rev_reg <= bearing_rev_next;
                pitch_reg       <= pitch_next;
                pitch_rev_reg   <= pitch_rev_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            tk_link_lost_reg    <= tick.link_lost;
            tk_manual_yaw_reg   <= tick.manual_yaw;
            tk_manual_pitch_reg <= tick.manual_pitch;
        end
        if (tk_fire)
        begin
            out_switch_reg <= !tk_link_lost_reg;
            out_yaw_reg    <= yaw_out;
            out_pitch_reg  <= pitch_out;
        end
    end

endmodule

// ===== hdl/two_axis_bounce_scan_unit.sv =====
// Two-axis bounce scan unit: triangle-wave sweep of bearing and pitch.
// A tick is held in the tick register, then its result in the result register until it transfers.
// One tick is taken per cycle while the receiver accepts results, since the state update
// between the tick register and the result register is combinational.
// rst_n (asynchronous, active low) clears the sweep state and the handshake
// and restores the register defaults. Depends on tbs_pkg, tbs_cfg, tbs_core.
`timescale 1ns / 1ps

module two_axis_bounce_scan_unit
    import tbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    tbs_tick_if.sink              tick,
    tbs_result_if.source          result
);

    cfg_t cfg;

    tbs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .result (result)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for two_axis_bounce_scan_unit.
// Drives ticks and APB register writes, predicts every angle command and
// compares it with the block's output; depends on tbs_pkg and both channel interfaces.
`timescale 1ns / 1ps

module testbench;
    import tbs_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic               sw_auto;
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
    } angle_cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tbs_tick_if   tick_ch ();
    tbs_result_if result_ch ();

    two_axis_bounce_scan_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch),
        .result  (result_ch)
    );

    // Shadow copy of the registers and of the sweep state.
    cfg_t       shadow_cfg;
    int         brg_cdeg;
    bit         brg_down;
    int         elev_cdeg;
    bit         elev_down;
    angle_cmd_t pending_cmds[$];

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advances the shadow sweep by one tick and returns the command it gives.
    function automatic angle_cmd_t advance_sweep(input bit lost, input bit man_yaw,
                                                 input bit man_pitch);
        angle_cmd_t cmd;
        int         upper;
        int         lower;
        int         step;
        int         y;
        int         p;
        if (!lost)
        begin
            cmd.sw_auto = 1'b1;
            cmd.yaw     = '0;
            cmd.pitch   = '0;
            return cmd;
        end
        if (shadow_cfg.pitch_continuous_servo)
        begin
            upper = int'(shadow_cfg.cr_pitch_max_cdeg);
            lower = int'(shadow_cfg.cr_pitch_min_cdeg);
        end
        else
        begin
            upper = int'(shadow_cfg.pitch_range_deg / 2) * int'(CDEG_PER_DEG);
            lower = -upper;
        end
        if (!man_yaw)
        begin
            step = 2 * int'(shadow_cfg.scan_speed_dps);
            brg_cdeg += brg_down ? -step : step;
            if (brg_cdeg < 0 && brg_down)
                brg_down = 1'b0;
            if (brg_cdeg > int'(BEARING_FULL) && !brg_down)
                brg_down = 1'b1;
            if (brg_cdeg < 0)
                brg_cdeg = 0;
            else if (brg_cdeg > int'(BEARING_FULL))
                brg_cdeg = int'(BEARING_FULL);
        end
        if (!man_pitch)
        begin
            step = 3 * int'(shadow_cfg.scan_speed_dps);
            elev_cdeg += elev_down ? -step : step;
            if (elev_cdeg < lower && elev_down)
                elev_down = 1'b0;
            if (elev_cdeg > upper && !elev_down)
                elev_down = 1'b1;
            // The lower limit wins when the limits cross.
            if (elev_cdeg < lower)
                elev_cdeg = lower;
            else if (elev_cdeg > upper)
                elev_cdeg = upper;
        end
        y = (brg_cdeg + int'(shadow_cfg.yaw_trim_cdeg)) % int'(BEARING_FULL);
        if (y < 0)
            y += int'(BEARING_FULL);
        if (y > int'(BEARING_HALF))
            y -= int'(BEARING_FULL);
        p = elev_cdeg + int'(shadow_cfg.pitch_trim_cdeg);
        if (p > int'(PITCH_OUT_LIMIT))
            p = int'(PITCH_OUT_LIMIT);
        if (p < -int'(PITCH_OUT_LIMIT))
            p = -int'(PITCH_OUT_LIMIT);
        cmd.sw_auto = 1'b0;
        cmd.yaw     = 16'(y);
        cmd.pitch   = 15'(p);
        return cmd;
    endfunction

    // Offers one tick, with a random gap first, and records its command once accepted.
    task automatic send_tick(input bit lost, input bit man_yaw, input bit man_pitch);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.link_lost    <= lost;
        tick_ch.manual_yaw   <= man_yaw;
        tick_ch.manual_pitch <= man_pitch;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        pending_cmds.push_back(advance_sweep(lost, man_yaw, man_pitch));
    endtask

    // Mostly scanning ticks, with manual holds and link returns mixed in.
    task automatic send_random_ticks(input int count);
        repeat (count)
            send_tick($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 15,
                      $urandom_range(0, 99) < 15);
    endtask

    // Stops offering ticks and waits until every command has come out.
    task automatic wait_idle;
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SCAN_SPEED:   shadow_cfg.scan_speed_dps         = value[6:0];
            REG_PITCH_CONT:   shadow_cfg.pitch_continuous_servo = value[0];
            REG_CR_PITCH_MAX: shadow_cfg.cr_pitch_max_cdeg      = value[14:0];
            REG_CR_PITCH_MIN: shadow_cfg.cr_pitch_min_cdeg      = value[14:0];
            REG_PITCH_RANGE:  shadow_cfg.pitch_range_deg        = value[7:0];
            REG_YAW_TRIM:     shadow_cfg.yaw_trim_cdeg          = value[10:0];
            REG_PITCH_TRIM:   shadow_cfg.pitch_trim_cdeg        = value[10:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_write_all(input int speed, input int cont, input int cr_max,
                                 input int cr_min, input int range_deg,
                                 input int yaw_ofs, input int pitch_ofs);
        wait_idle();
        cfg_write(REG_SCAN_SPEED, speed);
        cfg_write(REG_PITCH_CONT, cont);
        cfg_write(REG_CR_PITCH_MAX, cr_max);
        cfg_write(REG_CR_PITCH_MIN, cr_min);
        cfg_write(REG_PITCH_RANGE, range_deg);
        cfg_write(REG_YAW_TRIM, yaw_ofs);
        cfg_write(REG_PITCH_TRIM, pitch_ofs);
    endtask

    // Either bound or a value between them.
    function automatic int pick_in(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    task automatic test_directed;
        // Reset settings: link present, then every manual combination.
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        // Zero pitch range makes the pitch bounce on every tick.
        cfg_write_all(100, 0, 9000, -9000, 0, -1000, 1000);
        repeat (4) send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        // Continuous-servo limits with the lower limit above the upper one.
        cfg_write_all(100, 1, -2000, 3000, 180, 1000, -1000);
        repeat (3) send_tick(1'b1, 1'b0, 1'b0);
        // Zero speed freezes both axes even when they are free to move.
        cfg_write_all(0, 1, 9000, -9000, 180, 1000, 1000);
        repeat (2) send_tick(1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_random_sweeps;
        for (int phase = 0; phase < 8; phase++)
        begin
            int lim_a;
            int lim_b;
            lim_a = pick_in(-9000, 9000);
            lim_b = pick_in(-9000, 9000);
            // Keep the limits ordered most of the time.
            if ((lim_a > lim_b) && ($urandom_range(0, 3) != 0))
            begin
                lim_a = lim_a + lim_b;
                lim_b = lim_a - lim_b;
                lim_a = lim_a - lim_b;
            end
            if (phase == 5)
                // Beyond the documented ranges the arithmetic still has to hold.
                cfg_write_all(127, $urandom_range(0, 1), 16383, -16384, 255, 1023, -1024);
            else
                cfg_write_all(($urandom_range(0, 5) == 0) ? 0 : pick_in(50, 100),
                              $urandom_range(0, 1), lim_b, lim_a, pick_in(0, 180),
                              pick_in(-1000, 1000), pick_in(-1000, 1000));
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            send_random_ticks(190);
        end
    endtask

    task automatic test_backpressure;
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // The receiver holds off while ticks keep coming, so the input stalls.
        @(posedge clk);
        hold_left = 300;
        send_random_ticks(60);
        // The sender now pauses until every command is out, then resumes.
        wait_idle();
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        send_random_ticks(40);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        angle_cmd_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result with no tick waiting: auto %0b yaw %0d pitch %0d",
                             $realtime, result_ch.switch_to_auto, result_ch.yaw_cmd_cdeg,
                             result_ch.pitch_cmd_cdeg);
                mismatches++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (want.sw_auto !== result_ch.switch_to_auto ||
                    want.yaw !== result_ch.yaw_cmd_cdeg ||
                    want.pitch !== result_ch.pitch_cmd_cdeg)
                begin
                    if (mismatches < 10)
                        $display("%0t: expected auto %0b yaw %0d pitch %0d, got %0b %0d %0d",
                                 $realtime, want.sw_auto, want.yaw, want.pitch,
                                 result_ch.switch_to_auto, result_ch.yaw_cmd_cdeg,
                                 result_ch.pitch_cmd_cdeg);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if neither channel has made a transfer for too long.
    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.link_lost    = 1'b0;
        tick_ch.manual_yaw   = 1'b0;
        tick_ch.manual_pitch = 1'b0;
        mismatches           = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_left            = 0;
        quiet_cycles         = 0;
        shadow_cfg.scan_speed_dps         = SCAN_SPEED_RST;
        shadow_cfg.pitch_continuous_servo = 1'b0;
        shadow_cfg.cr_pitch_max_cdeg      = CR_PITCH_MAX_RST;
        shadow_cfg.cr_pitch_min_cdeg      = CR_PITCH_MIN_RST;
        shadow_cfg.pitch_range_deg        = PITCH_RANGE_RST;
        shadow_cfg.yaw_trim_cdeg          = '0;
        shadow_cfg.pitch_trim_cdeg        = '0;
        brg_cdeg  = 0;
        brg_down  = 1'b0;
        elev_cdeg = 0;
        elev_down = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_sweeps();
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
